@@ design/srgb_to_cielab_pixel_core_assert.svh @@
// ----------------------------------------------------------------------------
// srgb_to_cielab_pixel_core_assert.svh
// Assertion macros shared by the port checker.
// ----------------------------------------------------------------------------
`ifndef SRGB_TO_CIELAB_PIXEL_CORE_ASSERT_SVH
`define SRGB_TO_CIELAB_PIXEL_CORE_ASSERT_SVH

// same-cycle implication
`define S2C_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srgb_to_cielab_pixel_core: assertion failed");

// next-cycle implication
`define S2C_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srgb_to_cielab_pixel_core: assertion failed");

`endif

@@ design/s2c_pkg.sv @@
// ----------------------------------------------------------------------------
// s2c_pkg
// Constants, tables and types of the sRGB to CIELAB pixel core.
// ----------------------------------------------------------------------------
package s2c_pkg;

  localparam int FRAC_BITS = 8;

  localparam int LinW      = 17;  // linear channel, Q16, up to 1.0
  localparam int ProdW     = 41;
  localparam int SumW      = 43;
  localparam int NumW      = 48;  // dividend of the white-point divide
  localparam int RecipW    = 25;  // white-point reciprocal, 2^48 / white
  localparam int DProdW    = 57;  // upper 32 dividend bits times reciprocal
  localparam int RemW      = 27;  // remainder after the quotient estimate
  localparam int VW        = 25;
  localparam int FW        = 21;  // Lab curve output, Q20
  localparam int RootSteps = 21;
  localparam int TgtW      = 61;
  localparam int CubeW     = 64;
  localparam int SqW       = 42;
  localparam int LNumW     = 40;
  localparam int AccW      = 32;
  localparam int Shift     = 20 - FRAC_BITS;

  localparam int LMaxInt = ((100 << FRAC_BITS) > 32767) ? 32767 : (100 << FRAC_BITS);
  localparam logic [14:0] LMax = 15'(LMaxInt);

  localparam logic [23:0] Coef [3][3] = '{
    '{24'd4124564, 24'd3575761, 24'd1804375},
    '{24'd2126729, 24'd7151522, 24'd721750},
    '{24'd193339,  24'd1191920, 24'd9503041}
  };

  localparam logic [23:0] White [3] = '{24'd9504700, 24'd10000000, 24'd10888300};

  // floor(2^48 / white); the estimate is at most two below the true quotient
  localparam logic [RecipW-1:0] Recip [3] = '{
    RecipW'((64'd1 << 48) / 64'(White[0])),
    RecipW'((64'd1 << 48) / 64'(White[1])),
    RecipW'((64'd1 << 48) / 64'(White[2]))
  };

  localparam logic [VW-1:0] VOne = VW'(1) << 24;

  typedef logic [LinW-1:0] lin_rom_t [256];

  typedef struct packed {
    logic [14:0]        lightness;
    logic signed [15:0] green_red;
    logic signed [15:0] blue_yellow;
  } lab_t;

  function automatic logic [63:0] q30_mul(logic [63:0] a, logic [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  // sRGB transfer curve for one byte, Q16
  function automatic logic [LinW-1:0] lin_entry(int n);
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] y2;
    logic [63:0] p5;
    if (64'(n) * 64'd100000 <= 64'd1031475) begin
      return LinW'((64'(n) * 64'd6553600 + 64'd164730) / 64'd329460);
    end
    t = ((64'(1000 * n + 14025) << 30) + 64'd134512) / 64'd269025;
    if (t > (64'd1 << 30)) t = 64'd1 << 30;
    s  = q30_mul(t, t);
    lo = 64'd0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 64'd1) >> 1);
      y2  = q30_mul(mid, mid);
      p5  = q30_mul(q30_mul(y2, y2), mid);
      if (p5 <= s) lo = mid;
      else hi = mid - 64'd1;
    end
    return LinW'((s * lo + (64'd1 << 43)) >> 44);
  endfunction

  function automatic lin_rom_t build_lin_rom();
    lin_rom_t rom;
    for (int i = 0; i < 256; i++) rom[i] = lin_entry(i);
    return rom;
  endfunction

  localparam lin_rom_t LinRom = build_lin_rom();

endpackage

@@ design/s2c_xyz.sv @@
// ----------------------------------------------------------------------------
// s2c_xyz
// Linearization ROM, RGB to XYZ matrix and white-point dividend, 3 stages.
// ----------------------------------------------------------------------------
module s2c_xyz import s2c_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [7:0]      red_i,
  input  logic [7:0]      green_i,
  input  logic [7:0]      blue_i,
  output logic            valid_o,
  output logic [NumW-1:0] num_o [3]
);

  logic [2:0]       valid_q;
  logic [LinW-1:0]  lin_q  [3];
  logic [ProdW-1:0] prod_d [3][3];
  logic [ProdW-1:0] prod_q [3][3];
  logic [SumW-1:0]  sum    [3];
  logic [NumW-1:0]  num_d  [3];
  logic [NumW-1:0]  num_q  [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = ProdW'(lin_q[c]) * ProdW'(Coef[r][c]);
      end
      sum[r] = SumW'(prod_q[r][0]) + SumW'(prod_q[r][1]) + SumW'(prod_q[r][2]);
      // scale to Q24 and add half the divisor for rounding
      num_d[r] = NumW'({sum[r], 8'd0}) + NumW'(White[r] >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lin_q[0] <= LinRom[red_i];
      lin_q[1] <= LinRom[green_i];
      lin_q[2] <= LinRom[blue_i];
      prod_q   <= prod_d;
      num_q    <= num_d;
    end
  end

  assign valid_o = valid_q[2];
  assign num_o   = num_q;

endmodule

@@ design/s2c_div.sv @@
// ----------------------------------------------------------------------------
// s2c_div
// Divide by the white point: reciprocal estimate, remainder, fix-up, 3 stages.
// ----------------------------------------------------------------------------
module s2c_div import s2c_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [NumW-1:0] num_i [3],
  output logic            valid_o,
  output logic [VW-1:0]   v_o   [3]
);

  logic [2:0]        valid_q;
  logic [DProdW-1:0] prod_q [3];
  logic [NumW-1:0]   num_q  [3];
  logic [VW-1:0]     est_q  [3];
  logic [RemW-1:0]   rem_q  [3];
  logic [VW-1:0]     v_q    [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    localparam logic [RemW-1:0] W1 = RemW'(White[r]);
    localparam logic [RemW-1:0] W2 = RemW'(White[r]) << 1;
    logic [VW-1:0]   est;
    logic [NumW-1:0] back;
    logic [VW-1:0]   fix;
    assign est  = prod_q[r][DProdW-1:32];
    // est * white never exceeds the dividend, so NumW bits hold it
    assign back = NumW'(est) * NumW'(White[r]);
    assign fix  = (rem_q[r] >= W2) ? VW'(2) : ((rem_q[r] >= W1) ? VW'(1) : VW'(0));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        prod_q[r] <= DProdW'(num_i[r][NumW-1:16]) * DProdW'(Recip[r]);
        num_q[r]  <= num_i[r];
        est_q[r]  <= est;
        rem_q[r]  <= RemW'(num_q[r] - back);
        v_q[r]    <= est_q[r] + fix;
      end
    end
  end

  assign valid_o = valid_q[2];
  assign v_o     = v_q;

endmodule

@@ design/s2c_lab_curve.sv @@
// ----------------------------------------------------------------------------
// s2c_lab_curve
// Lab companding: bitwise cube root next to the kappa-line divide.
// ----------------------------------------------------------------------------
module s2c_lab_curve import s2c_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [VW-1:0] v_i [3],
  output logic          valid_o,
  output logic [FW-1:0] f_o [3]
);

  localparam logic [LNumW-1:0] Knee   = LNumW'(216) << 24;
  localparam logic [LNumW-1:0] Offset = (LNumW'(432) << 24) + LNumW'(25056);

  // 50112 = 64 * 783: drop 6 bits, then multiply by ceil(2^38 / 783)
  localparam int KNumW   = 28;
  localparam int KRecipW = 29;
  localparam int KProdW  = KNumW + KRecipW;
  localparam logic [KRecipW-1:0] KRecip = KRecipW'(((64'd1 << 38) + 64'd782) / 64'd783);

  logic [RootSteps:0] valid_q;

  // prep stage
  logic [TgtW-1:0]  tgt_q  [3];
  logic [KNumW-1:0] lnum_q [3];
  logic             lin_q  [3];

  // root stages
  logic [FW-1:0]     q_q     [RootSteps][3];
  logic [SqW-1:0]    q2_q    [RootSteps][3];
  logic [CubeW-1:0]  q3_q    [RootSteps][3];
  logic [TgtW-1:0]   t_q     [RootSteps][3];
  logic              lsel_q  [RootSteps][3];
  logic [KProdW-1:0] lprod_q [3];
  logic [FW-1:0]     lquo_q  [RootSteps-1][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[RootSteps-1:0], valid_i};
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_prep
    logic [VW-1:0]    vc;
    logic [LNumW-1:0] scaled;
    assign vc     = (v_i[r] > VOne) ? VOne : v_i[r];
    assign scaled = LNumW'(vc) * LNumW'(24389);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tgt_q[r]  <= TgtW'(vc) << 36;
        lnum_q[r] <= KNumW'((scaled + Offset) >> 6);
        lin_q[r]  <= !(scaled > Knee);
      end
    end
  end

  for (genvar j = 0; j < RootSteps; j++) begin : g_root
    localparam int K = RootSteps - 1 - j;
    for (genvar r = 0; r < 3; r++) begin : g_row
      logic [FW-1:0]    q_in;
      logic [SqW-1:0]   q2_in;
      logic [CubeW-1:0] q3_in;
      logic [TgtW-1:0]  t_in;
      logic             lsel_in;
      logic [CubeW-1:0] cand2;
      logic [CubeW-1:0] cand3;
      logic [CubeW-1:0] q2x3;
      logic [CubeW-1:0] qx3;
      logic             take;
      if (j == 0) begin : g_first
        assign q_in    = '0;
        assign q2_in   = '0;
        assign q3_in   = '0;
        assign t_in    = tgt_q[r];
        assign lsel_in = lin_q[r];
      end else begin : g_next
        assign q_in    = q_q[j-1][r];
        assign q2_in   = q2_q[j-1][r];
        assign q3_in   = q3_q[j-1][r];
        assign t_in    = t_q[j-1][r];
        assign lsel_in = lsel_q[j-1][r];
      end
      // (q + d)^2 and (q + d)^3 with d a power of two
      assign q2x3  = (CubeW'(q2_in) << 1) + CubeW'(q2_in);
      assign qx3   = (CubeW'(q_in) << 1) + CubeW'(q_in);
      assign cand2 = CubeW'(q2_in) + (CubeW'(q_in) << (K + 1)) + (CubeW'(1) << (2 * K));
      assign cand3 = q3_in + (q2x3 << K) + (qx3 << (2 * K)) + (CubeW'(1) << (3 * K));
      assign take  = cand3 <= CubeW'(t_in);
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          q_q[j][r]    <= take ? (q_in | (FW'(1) << K)) : q_in;
          q2_q[j][r]   <= take ? SqW'(cand2) : q2_in;
          q3_q[j][r]   <= take ? cand3 : q3_in;
          t_q[j][r]    <= t_in;
          lsel_q[j][r] <= lsel_in;
        end
      end
      // kappa line: product, quotient, then carried beside the root
      if (j == 0) begin : g_kprod
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            lprod_q[r] <= KProdW'(lnum_q[r]) * KProdW'(KRecip);
          end
        end
      end else if (j == 1) begin : g_kquo
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            lquo_q[0][r] <= FW'(lprod_q[r][KProdW-1:38]);
          end
        end
      end else begin : g_kcarry
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            lquo_q[j-1][r] <= lquo_q[j-2][r];
          end
        end
      end
    end
  end

  assign valid_o = valid_q[RootSteps];
  for (genvar r = 0; r < 3; r++) begin : g_out
    assign f_o[r] = lsel_q[RootSteps-1][r] ? lquo_q[RootSteps-2][r] : q_q[RootSteps-1][r];
  end

endmodule

@@ design/s2c_lab_out.sv @@
// ----------------------------------------------------------------------------
// s2c_lab_out
// L, a, b scaling, round half up and saturation, 2 stages.
// ----------------------------------------------------------------------------
module s2c_lab_out import s2c_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [FW-1:0] f_i [3],
  output logic          valid_o,
  output lab_t          lab_o
);

  localparam logic signed [AccW-1:0] Half   = AccW'(1) << (Shift - 1);
  localparam logic signed [AccW-1:0] LBias  = AccW'(16) << 20;

  logic [1:0] valid_q;
  logic signed [AccW-1:0] f0s, f1s, f2s;
  logic signed [AccW-1:0] tl_d, ta_d, tb_d;
  logic signed [AccW-1:0] tl_q, ta_q, tb_q;
  logic signed [AccW-1:0] rl, ra, rb;
  lab_t lab_d, lab_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[0], valid_i};
    end
  end

  always_comb begin
    f0s  = $signed(AccW'(f_i[0]));
    f1s  = $signed(AccW'(f_i[1]));
    f2s  = $signed(AccW'(f_i[2]));
    tl_d = 32'sd116 * f1s - LBias;
    ta_d = 32'sd500 * (f0s - f1s);
    tb_d = 32'sd200 * (f1s - f2s);

    rl = (tl_q + Half) >>> Shift;
    ra = (ta_q + Half) >>> Shift;
    rb = (tb_q + Half) >>> Shift;

    if (rl < 0)                    lab_d.lightness = '0;
    else if (rl > AccW'(LMaxInt))  lab_d.lightness = LMax;
    else                           lab_d.lightness = 15'(rl);

    if (ra > 32'sd32767)           lab_d.green_red = 16'sh7fff;
    else if (ra < -32'sd32768)     lab_d.green_red = 16'sh8000;
    else                           lab_d.green_red = 16'(ra);

    if (rb > 32'sd32767)           lab_d.blue_yellow = 16'sh7fff;
    else if (rb < -32'sd32768)     lab_d.blue_yellow = 16'sh8000;
    else                           lab_d.blue_yellow = 16'(rb);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tl_q  <= tl_d;
      ta_q  <= ta_d;
      tb_q  <= tb_d;
      lab_q <= lab_d;
    end
  end

  assign valid_o = valid_q[1];
  assign lab_o   = lab_q;

endmodule

@@ design/s2c_outq.sv @@
// ----------------------------------------------------------------------------
// s2c_outq
// Two-entry output queue; decouples the result stall from the pipeline.
// ----------------------------------------------------------------------------
module s2c_outq import s2c_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  lab_t data_i,
  output logic room_o,
  output logic valid_o,
  input  logic stall_i,
  output lab_t data_o
);

  lab_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign pop     = (cnt_q != 2'd0) && !stall_i;
  assign room_o  = cnt_q != 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop)    rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

@@ design/srgb_to_cielab_pixel_core.sv @@
// ----------------------------------------------------------------------------
// srgb_to_cielab_pixel_core
// sRGB bytes to CIELAB (D65), fully pipelined, one pixel per unstalled clock.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------
//  in      | valid_i / stall_o  | red_i, green_i, blue_i (8 b each)
//  out     | valid_o / stall_i  | lightness_o (15 b), green_red_axis_o,
//          |                    | blue_yellow_axis_o (16 b signed)
//
//  One beat per clock sustained while the output queue has room; 30 register
//  stages to the output queue (3 matrix, 3 white divide, 22 Lab curve,
//  2 output stages), set by the one-bit-per-stage cube root.
//  Reset clears all valid bits and the queue; payload flops are not reset.
//  A held result sits in a 2-entry queue; the pipeline freezes as a whole
//  only once the queue is full, so no beat is lost or repeated.
// ----------------------------------------------------------------------------
module srgb_to_cielab_pixel_core import s2c_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [14:0] lightness_o,
  output logic [15:0] green_red_axis_o,
  output logic [15:0] blue_yellow_axis_o
);

  logic            en;          // pipeline advance, from queue room
  logic            xyz_valid, div_valid, crv_valid, lab_valid;
  logic [NumW-1:0] num [3];
  logic [VW-1:0]   v   [3];
  logic [FW-1:0]   f   [3];
  lab_t            lab, head;

  assign stall_o = !en;

  // linearize, matrix, white dividend
  s2c_xyz u_xyz (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_i),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .valid_o (xyz_valid),
    .num_o   (num)
  );

  // normalize by white into Q24
  s2c_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (xyz_valid),
    .num_i   (num),
    .valid_o (div_valid),
    .v_o     (v)
  );

  // cube root or kappa line, Q20
  s2c_lab_curve u_curve (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_valid),
    .v_i     (v),
    .valid_o (crv_valid),
    .f_o     (f)
  );

  s2c_lab_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (crv_valid),
    .f_i     (f),
    .valid_o (lab_valid),
    .lab_o   (lab)
  );

  // push only on an advancing clock so the last stage moves exactly once
  s2c_outq u_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (lab_valid && en),
    .data_i  (lab),
    .room_o  (en),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .data_o  (head)
  );

  assign lightness_o        = head.lightness;
  assign green_red_axis_o   = head.green_red;
  assign blue_yellow_axis_o = head.blue_yellow;

endmodule

@@ design/s2c_port_checker.sv @@
// ----------------------------------------------------------------------------
// s2c_port_checker
// Port-level checks on the pixel core, bound to the top level.
// ----------------------------------------------------------------------------
`include "srgb_to_cielab_pixel_core_assert.svh"

module s2c_port_checker import s2c_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        stall_o,
  input logic        valid_o,
  input logic        stall_i,
  input logic [14:0] lightness_o,
  input logic [15:0] green_red_axis_o,
  input logic [15:0] blue_yellow_axis_o
);

  logic [46:0] out_bits;

  assign out_bits = {lightness_o, green_red_axis_o, blue_yellow_axis_o};

  // held result stays offered
  `S2C_ASSERT_NEXT(a_out_hold, valid_o && stall_i, valid_o)

  // held result does not change
  `S2C_ASSERT_NEXT(a_out_stable, valid_o && stall_i, $stable(out_bits))

  // input never stalls while no result is waiting
  `S2C_ASSERT_NOW(a_no_idle_stall, !valid_o, !stall_o)

  // lightness stays within range
  `S2C_ASSERT_NOW(a_l_range, valid_o, lightness_o <= LMax)

endmodule

bind srgb_to_cielab_pixel_core s2c_port_checker u_port_checker (.*);
